// File: sv/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted list table: the request and
// response payloads, the request codes, the status codes and the default
// list capacity.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 32;

  // Request codes.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_INSERT     = 3'd2;
  localparam logic [2:0] REQ_REMOVE     = 3'd3;
  localparam logic [2:0] REQ_READ       = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               position;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [5:0]               entry_count;
  } rsp_t;

endpackage

// File: sv/slt_mem.sv
// ----------------------------------------------------------------------------
// slt_mem
// Entry storage of the list: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module slt_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [slt_pkg::DATA_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [slt_pkg::DATA_W-1:0] wr_data
);
  import slt_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/slt_seq.sv
// ----------------------------------------------------------------------------
// slt_seq
// Request sequencer: searches the entry memory, shifts entries to open or
// close a gap, reads entries by position and keeps the entry count.
// ----------------------------------------------------------------------------
module slt_seq #(
  parameter int CAPACITY = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  slt_pkg::req_t              req,
  output logic                       res_valid,
  input  logic                       res_ready,
  output slt_pkg::rsp_t              res,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [slt_pkg::DATA_W-1:0] rd_data,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [slt_pkg::DATA_W-1:0] wr_data
);
  import slt_pkg::*;

  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [2:0]        op, op_next;
  logic [DATA_W-1:0] val, val_next;
  logic [CW-1:0]     len, len_next;
  logic [CW-1:0]     scan, scan_next;
  logic              pend, pend_next;
  logic [AW-1:0]     pend_addr, pend_addr_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [CW-1:0]     at, at_next;
  logic              up, up_next;
  logic              wr_pend, wr_pend_next;
  logic [AW-1:0]     wr_tgt, wr_tgt_next;
  logic [1:0]        status, status_next;
  logic [DATA_W-1:0] rd_val, rd_val_next;

  logic          accept;
  logic          hit;
  logic          more;
  logic [CW:0]   ptr_inc;
  logic          pos_ok;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_valid = (state == S_RESULT);

  assign res.status      = status;
  assign res.read_value  = rd_val;
  assign res.entry_count = 6'(len);

  assign ptr_inc = {1'b0, ptr} + 1'b1;
  assign more    = (scan < len);
  assign pos_ok  = (PW'(req.position) < PW'(len)) && (PW'(req.position) < PW'(CAPACITY));

  // A search hit: first entry not less than the value for an insert,
  // first entry equal to it for a remove.
  always_comb begin
    if (op == REQ_INSERT) begin
      hit = pend && ($signed(rd_data) >= $signed(val));
    end else begin
      hit = pend && (rd_data == val);
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    val_next       = val;
    len_next       = len;
    scan_next      = scan;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    ptr_next       = ptr;
    at_next        = at;
    up_next        = up;
    wr_pend_next   = wr_pend;
    wr_tgt_next    = wr_tgt;
    status_next    = status;
    rd_val_next    = rd_val;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = wr_tgt;
    wr_data        = val;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next      = req.req_type;
          val_next     = req.value;
          status_next  = ST_DONE;
          rd_val_next  = '0;
          scan_next    = '0;
          pend_next    = 1'b0;
          wr_pend_next = 1'b0;
          case (req.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
              if (len >= CW'(CAPACITY)) begin
                status_next = ST_FULL;
                state_next  = S_RESULT;
              end else if (req.req_type == REQ_INSERT) begin
                state_next = S_SEARCH;
              end else begin
                at_next    = (req.req_type == REQ_PUSH_FRONT) ? '0 : len;
                ptr_next   = len;
                up_next    = 1'b1;
                state_next = S_SHIFT;
              end
            end
            REQ_REMOVE: begin
              state_next = S_SEARCH;
            end
            REQ_READ: begin
              if (pos_ok) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(req.position);
                state_next = S_READ;
              end else begin
                status_next = ST_MISS;
                state_next  = S_RESULT;
              end
            end
            default: begin
              status_next = ST_MISS;
              state_next  = S_RESULT;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // Reads are issued back to back; each compare sees the entry read
        // in the cycle before.
        if (more && !hit) begin
          rd_en          = 1'b1;
          rd_addr        = scan[AW-1:0];
          scan_next      = scan + 1'b1;
          pend_addr_next = scan[AW-1:0];
        end
        pend_next = more && !hit;
        if (hit) begin
          at_next    = CW'(pend_addr);
          up_next    = (op == REQ_INSERT);
          ptr_next   = (op == REQ_INSERT) ? len : CW'(pend_addr);
          state_next = S_SHIFT;
        end else if (!pend && !more) begin
          if (op == REQ_INSERT) begin
            at_next    = len;
            ptr_next   = len;
            up_next    = 1'b1;
            state_next = S_SHIFT;
          end else begin
            status_next = ST_MISS;
            state_next  = S_RESULT;
          end
        end
      end

      S_SHIFT: begin
        // Each move writes the entry read in the cycle before. Read and
        // write addresses never meet within the same pass.
        if (wr_pend) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
        end
        if (up) begin
          if (ptr > at) begin
            rd_en        = 1'b1;
            rd_addr      = AW'(ptr - 1'b1);
            wr_pend_next = 1'b1;
            wr_tgt_next  = ptr[AW-1:0];
            ptr_next     = ptr - 1'b1;
          end else begin
            wr_pend_next = 1'b0;
            if (!wr_pend) begin
              wr_en      = 1'b1;
              wr_addr    = at[AW-1:0];
              wr_data    = val;
              len_next   = len + 1'b1;
              state_next = S_RESULT;
            end
          end
        end else begin
          if (ptr_inc < {1'b0, len}) begin
            rd_en        = 1'b1;
            rd_addr      = ptr_inc[AW-1:0];
            wr_pend_next = 1'b1;
            wr_tgt_next  = ptr[AW-1:0];
            ptr_next     = ptr_inc[CW-1:0];
          end else begin
            wr_pend_next = 1'b0;
            if (!wr_pend) begin
              len_next   = len - 1'b1;
              state_next = S_RESULT;
            end
          end
        end
      end

      S_READ: begin
        rd_val_next = rd_data;
        state_next  = S_RESULT;
      end

      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      len     <= '0;
      pend    <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      state   <= state_next;
      len     <= len_next;
      pend    <= pend_next;
      wr_pend <= wr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    val       <= val_next;
    scan      <= scan_next;
    pend_addr <= pend_addr_next;
    ptr       <= ptr_next;
    at        <= at_next;
    up        <= up_next;
    wr_tgt    <= wr_tgt_next;
    status    <= status_next;
    rd_val    <= rd_val_next;
  end

endmodule

// File: sv/sorted_list_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_table_unit
// Bounded ordered list of signed 32-bit values with push front, push back,
// sorted insert, remove first equal and read by position.
// ----------------------------------------------------------------------------
// The list lives in a single memory of CAPACITY entries with one read and
// one write port; a sequencer walks it one entry per cycle. One request is
// worked at a time and each gives exactly one response transfer. Push
// front and sorted insert open a gap by moving every entry behind the
// insertion point up by one, and remove closes the gap behind the removed
// entry; the search and the move each run at one entry per cycle, set by
// the single read port of the entry memory. The response sits in an output
// register, so the next request transfer is taken while an earlier
// response still waits. No clearing pass is needed after reset: only
// entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_list_table_unit #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  slt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output slt_pkg::rsp_t rsp
);
  import slt_pkg::*;

  // Address width of the entry memory and width of the entry count, which
  // must be able to hold CAPACITY itself.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic              res_valid;
  logic              res_ready;
  rsp_t              res;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  slt_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  slt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // The output register takes a finished response whenever it is empty or
  // its current response transfers in the same cycle.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

// File: tb/sv/sorted_list_table_checker.sv
// ----------------------------------------------------------------------------
// sorted_list_table_checker
// Watches both channels of the sorted list table, keeps its own copy of the
// list, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module sorted_list_table_checker #(
  parameter int CAPACITY = slt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  slt_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  slt_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending,
  output int            checked,
  output int            peak_len,
  output int            full_drops,
  output int            misses
);
  import slt_pkg::*;

  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int   list_len   = 0;
  rsp_t rsp_due [$];
  int   errs       = 0;
  int   n_checked  = 0;
  int   n_full     = 0;
  int   n_miss     = 0;
  int   n_peak     = 0;

  // Applies one request to the local list and returns the response it must
  // produce.
  function automatic rsp_t apply_to_list(input req_t r);
    rsp_t o;
    int   at;
    int   i;
    o        = '0;
    o.status = ST_DONE;
    at       = 0;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
        if (list_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          if (r.req_type == REQ_PUSH_BACK) begin
            at = list_len;
          end else if (r.req_type == REQ_INSERT) begin
            while (at < list_len && list_mem[at] < $signed(r.value)) at++;
          end
          for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = r.value;
          list_len++;
        end
      end
      REQ_REMOVE: begin
        while (at < list_len && list_mem[at] != r.value) at++;
        if (at < list_len) begin
          for (i = at; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end else begin
          o.status = ST_MISS;
        end
      end
      REQ_READ: begin
        if (int'(r.position) < list_len) begin
          o.read_value = list_mem[r.position];
        end else begin
          o.status = ST_MISS;
        end
      end
      default: begin
        o.status = ST_MISS;
      end
    endcase
    o.entry_count = 6'(list_len);
    return o;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      list_len = 0;
      rsp_due.delete();
    end else begin
      // Responses are handled first; a request taken at the same edge can
      // only be answered later.
      if (rsp_valid && rsp_ready) begin
        if (rsp_due.size() == 0) begin
          $display({"%0t: response transfer with no request outstanding, expected none, ",
                    "actual status %0d value %0d count %0d"},
                   $time, rsp.status, rsp.read_value, rsp.entry_count);
          errs++;
        end else begin
          want = rsp_due.pop_front();
          n_checked++;
          check_field("status", want.status, rsp.status);
          check_field("read_value", want.read_value, $signed(rsp.read_value));
          check_field("entry_count", want.entry_count, rsp.entry_count);
        end
      end
      if (req_valid && req_ready) begin
        want = apply_to_list(req);
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_MISS) n_miss++;
        if (list_len > n_peak) n_peak = list_len;
        rsp_due.push_back(want);
      end
    end
    fail_count <= errs;
    pending    <= rsp_due.size();
    checked    <= n_checked;
    peak_len   <= n_peak;
    full_drops <= n_full;
    misses     <= n_miss;
  end

endmodule

// File: tb/sv/sorted_list_table_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_table_unit_tb
// Drives requests into the sorted list table and gives the verdict; a
// separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
// A short directed run covers reads and removes on an empty list, all three
// ways of adding an entry, ties and extreme values for the sorted insert,
// reads at, past and far past the count, removes that miss, and the unused
// request codes. Random blocks then alternate between filling the list until
// it is full and draining it towards empty, under four handshake settings:
// no idling, an idle sender, a stalling receiver, and both at once.
// ----------------------------------------------------------------------------
module sorted_list_table_unit_tb;
  import slt_pkg::*;

  // The slowest correct gap between two transfers is a full shift of the
  // list plus a long random gap on either side.
  localparam int WATCHDOG_LIMIT = 5000;
  // Quiet time after the last response.
  localparam int DRAIN_CYCLES   = 150;
  localparam int BLOCK_ITEMS    = 85;
  localparam int POOL_SIZE      = 12;
  localparam int RECENT_MAX     = 64;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b1;
  rsp_t rsp;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles       = 0;
  int sent_by_code [8]   = '{default: 0};

  int fail_count;
  int pending;
  int checked;
  int peak_len;
  int full_drops;
  int misses;

  // Values the random part draws on often, so that sorted inserts hit ties
  // and removes find their target. The extremes of the signed range are in.
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd7, -32'sd7, 32'sd100,
    32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFE, 32'sh80000001
  };

  // Rough picture of what the list holds, used to aim removes at values
  // that are likely present.
  logic signed [DATA_W-1:0] recent_vals [$];

  sorted_list_table_unit #(.CAPACITY(CAPACITY_DEF)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sorted_list_table_checker #(.CAPACITY(CAPACITY_DEF)) list_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .peak_len   (peak_len),
    .full_drops (full_drops),
    .misses     (misses)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver decides afresh at every edge whether it takes a response.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // The watchdog counts cycles in which neither channel completes a
  // transfer and ends the run if the block stops making progress.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
               $time, quiet_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [2:0] code, input logic signed [DATA_W-1:0] v,
                                    input logic [4:0] pos);
    req_t r;
    r.req_type = code;
    r.value    = v;
    r.position = pos;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(9) < 4) begin
      return value_pool[$urandom_range(POOL_SIZE-1)];
    end
    return $urandom;
  endfunction

  // Builds one random request. A filling block mostly adds entries so that
  // the list reaches its capacity; a draining block mostly removes them.
  function automatic req_t random_request(input bit draining);
    req_t r;
    int   roll;
    int   k;
    roll       = $urandom_range(99);
    r.value    = pick_value();
    r.position = ($urandom_range(1) != 0) ? 5'($urandom_range(7)) : 5'($urandom);
    if (roll >= 96) begin
      r.req_type = REQ_READ + 3'($urandom_range(1, 3));
    end else if (draining) begin
      if (roll < 4)       r.req_type = REQ_PUSH_FRONT;
      else if (roll < 8)  r.req_type = REQ_PUSH_BACK;
      else if (roll < 16) r.req_type = REQ_INSERT;
      else if (roll < 76) r.req_type = REQ_REMOVE;
      else                r.req_type = REQ_READ;
    end else begin
      if (roll < 20)      r.req_type = REQ_PUSH_FRONT;
      else if (roll < 40) r.req_type = REQ_PUSH_BACK;
      else if (roll < 65) r.req_type = REQ_INSERT;
      else if (roll < 80) r.req_type = REQ_REMOVE;
      else                r.req_type = REQ_READ;
    end
    // Most removes name a value that was added earlier and not yet taken.
    if (r.req_type == REQ_REMOVE && recent_vals.size() > 0 && $urandom_range(9) < 8) begin
      k       = $urandom_range(recent_vals.size() - 1);
      r.value = recent_vals[k];
      recent_vals.delete(k);
    end
    return r;
  endfunction

  // Presents one request and returns at the edge where its transfer takes
  // place. Valid may drop only before the payload is offered, never while
  // a request waits for ready.
  task automatic send_request(input req_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_by_code[item.req_type]++;
    if (item.req_type == REQ_PUSH_FRONT || item.req_type == REQ_PUSH_BACK ||
        item.req_type == REQ_INSERT) begin
      recent_vals.push_back(item.value);
      if (recent_vals.size() > RECENT_MAX) void'(recent_vals.pop_front());
    end
  endtask

  initial begin
    int phase;
    int blk;
    int n;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The list starts empty, so reads and removes miss.
    send_request(make_req(REQ_READ, 32'sd0, 5'd0));
    send_request(make_req(REQ_REMOVE, 32'sd0, 5'd0));
    // An insert into an empty list lands at the tail.
    send_request(make_req(REQ_INSERT, 32'sd5, 5'd0));
    send_request(make_req(REQ_PUSH_BACK, 32'sh80000000, 5'd0));
    send_request(make_req(REQ_PUSH_FRONT, 32'sh7FFFFFFF, 5'd0));
    // The list is now not in order, so the insert stops at the first entry
    // that is not less than the value, even if smaller ones follow.
    send_request(make_req(REQ_INSERT, 32'sd5, 5'd0));
    send_request(make_req(REQ_INSERT, 32'sh80000000, 5'd0));
    send_request(make_req(REQ_INSERT, 32'sh7FFFFFFF, 5'd0));
    // Reads at the head, at the last entry, just past it and far past it.
    send_request(make_req(REQ_READ, 32'sd0, 5'd0));
    send_request(make_req(REQ_READ, 32'sd0, 5'd5));
    send_request(make_req(REQ_READ, 32'sd0, 5'd6));
    send_request(make_req(REQ_READ, -32'sd1, 5'd31));
    // Removes that find a duplicate, an extreme and nothing at all.
    send_request(make_req(REQ_REMOVE, 32'sd5, 5'd0));
    send_request(make_req(REQ_REMOVE, 32'sh80000000, 5'd0));
    send_request(make_req(REQ_REMOVE, 32'sd12345, 5'd0));
    send_request(make_req(REQ_REMOVE, -32'sd1, 5'd0));
    // Unused request codes leave the list alone and report a miss.
    send_request(make_req(REQ_READ + 3'd1, -32'sd1, 5'd31));
    send_request(make_req(REQ_READ + 3'd2, 32'sd0, 5'd0));
    send_request(make_req(REQ_READ + 3'd3, 32'sh7FFFFFFF, 5'd1));
    send_request(make_req(REQ_READ, 32'sd0, 5'd1));

    // Random part: four handshake settings, each with alternating fill and
    // drain blocks so that the full list and the empty list recur.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 68;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 68;
        end
        default: begin
          sender_idle_pct    = 26;
          receiver_stall_pct = 26;
        end
      endcase
      for (blk = 0; blk < 4; blk++) begin
        for (n = 0; n < BLOCK_ITEMS; n++) send_request(random_request(blk[0]));
      end
    end
    req_valid <= 1'b0;

    // Let the last transfer reach the checker, wait for every response and
    // then watch a while longer for anything unexpected.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d push front, %0d push back, %0d sorted insert, %0d remove, %0d read, %0d unused code",
             sent_by_code[REQ_PUSH_FRONT], sent_by_code[REQ_PUSH_BACK], sent_by_code[REQ_INSERT],
             sent_by_code[REQ_REMOVE], sent_by_code[REQ_READ],
             sent_by_code[5] + sent_by_code[6] + sent_by_code[7]);
    $display("Responses checked: %0d; longest list %0d of %0d, %0d inserts refused when full, %0d misses",
             checked, peak_len, CAPACITY_DEF, full_drops, misses);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
